// File: rtl/periodic_chirp_generator_macros.svh
// ----------------------------------------------------------------------------
// Periodic chirp generator assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_CHIRP_GENERATOR_MACROS_SVH
`define PERIODIC_CHIRP_GENERATOR_MACROS_SVH

// check that is switched off while reset is held
`define PCG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also runs through reset
`define PCG_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/pcg_pkg.sv
// ----------------------------------------------------------------------------
// Periodic chirp generator package
// Shared widths, fixed-point constants, divisor tables and types.
// ----------------------------------------------------------------------------
package pcg_pkg;

  localparam int unsigned PCG_MAX_LENGTH = 4096;
  localparam int unsigned PCG_IDX_W      = 12;
  localparam int unsigned PCG_SQ_W       = 2 * PCG_IDX_W;
  localparam int unsigned PCG_LEN_W      = 13;
  localparam int unsigned PCG_RATE_W     = 14;
  localparam int unsigned PCG_X_W        = 31;
  localparam int unsigned PCG_OUT_W      = 16;

  // pi/2 and 1.0 in Q1.30
  localparam logic [30:0] PCG_HALFPI_Q30 = 31'd1686629713;
  localparam logic [30:0] PCG_ONE_Q30    = 31'h4000_0000;
  localparam logic [31:0] PCG_HALF_Q15   = 32'd16384;

  // Horner divisors of the sine and cosine series
  localparam int unsigned PCG_SIN_DIV [6] = '{156, 110, 72, 42, 20, 6};
  localparam int unsigned PCG_COS_DIV [6] = '{182, 132, 90, 56, 30, 12};
  localparam int unsigned PCG_COS_LAST_DIV = 2;
  localparam int unsigned PCG_POLY_STEPS   = 6;

  // configuration register indexes
  localparam logic PCG_REG_LENGTH = 1'b0;
  localparam logic PCG_REG_RATE   = 1'b1;

  typedef enum logic [1:0] {
    CFG_IDLE,
    CFG_LOAD,
    CFG_RATE,
    CFG_PROD
  } pcg_cfg_state_t;

  // one sample in flight through the series evaluation
  typedef struct packed {
    logic [30:0] x;
    logic [31:0] x2;
    logic [30:0] hs;
    logic [30:0] hc;
    logic [1:0]  quad;
  } pcg_poly_t;

endpackage

// File: rtl/periodic_chirp_generator.sv
// ----------------------------------------------------------------------------
// Periodic chirp generator
// Gives cos and sin (Q1.15) of pi*r/L, r = ((L+1)*n*m*m) mod 2L, per index m.
// ----------------------------------------------------------------------------
//  channel  dir  handshake               payload
//  in_      in   in_tvalid / in_tready   in_tdata[11:0]  sample_index
//  out_     out  out_tvalid / out_tready out_tdata[15:0] cos, [31:16] sin
//  cfg_     in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One sample per cycle sustained while the output is not stalled and no register
// write or K rebuild holds in_tready low; the mod and divide run one bit per stage.
// After reset and after every register write the bit-serial K unit runs with
// in_tready low; the write beat itself also holds in_tready low in its own cycle.
// A stall at the output freezes the whole pipeline; a 4-beat queue keeps
// accepting input meanwhile.
module periodic_chirp_generator
  import pcg_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = PCG_MAX_LENGTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [11:0] sample_index
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // [15:0] cos_value, [31:16] sin_value
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [PCG_RATE_W-1:0] cfg_data
);

  localparam int unsigned LW = $clog2(MAX_LENGTH + 1);
  localparam int unsigned MW = LW + 1;

  logic                 busy;
  logic [LW-1:0]        len;
  logic [MW-1:0]        modv, kval;
  logic                 item_valid, take;
  logic [PCG_IDX_W-1:0] item_index;
  logic [PCG_OUT_W-1:0] cos_v, sin_v;

  pcg_cfg #(.MAX_LENGTH(MAX_LENGTH)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .len_o     (len),
    .mod_o     (modv),
    .kval_o    (kval)
  );

  pcg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .busy       (busy),
    .item_valid (item_valid),
    .item_index (item_index),
    .take       (take)
  );

  pcg_back #(.MAX_LENGTH(MAX_LENGTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_index (item_index),
    .take       (take),
    .len_i      (len),
    .mod_i      (modv),
    .kval_i     (kval),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .cos_o      (cos_v),
    .sin_o      (sin_v)
  );

  assign out_tdata = {sin_v, cos_v};

endmodule

// File: rtl/pcg_cfg.sv
// ----------------------------------------------------------------------------
// Periodic chirp generator configuration unit
// Holds length and rate, and derives K = ((L+1)*n) mod 2L bit-serially.
// ----------------------------------------------------------------------------
module pcg_cfg
  import pcg_pkg::*;
#(
  parameter  int unsigned MAX_LENGTH = PCG_MAX_LENGTH,
  localparam int unsigned LW = $clog2(MAX_LENGTH + 1),
  localparam int unsigned MW = LW + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [PCG_RATE_W-1:0] cfg_data,
  output logic                  busy,
  output logic [LW-1:0]         len_o,
  output logic [MW-1:0]         mod_o,
  output logic [MW-1:0]         kval_o
);

  localparam int unsigned PW = 2 * MW;
  localparam int unsigned WW = (PW > PCG_RATE_W) ? PW : PCG_RATE_W;
  localparam int unsigned CW = $clog2(WW + 1);

  pcg_cfg_state_t state_r, state_nxt;
  logic [PCG_LEN_W-1:0]  len_r;
  logic [PCG_RATE_W-1:0] rate_r;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [MW-1:0]         rem_r, rem_nxt;
  logic [WW-1:0]         word_r, word_nxt;
  logic [MW-1:0]         kval_r, kval_nxt;
  logic                  we;
  logic [LW-1:0]         lenc;
  logic [MW-1:0]         modv;
  logic [MW-1:0]         aval;
  logic [MW-1:0]         nres;
  logic [PW-1:0]         prod;
  logic [PCG_RATE_W-1:0] absn;

  function automatic logic [MW-1:0] mod_step(input logic [MW-1:0] rem, input logic b,
                                             input logic [MW-1:0] md);
    logic [MW:0] t;
    t = {rem, b};
    if (t >= {1'b0, md}) t = t - {1'b0, md};
    return t[MW-1:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign we        = cfg_valid && cfg_ready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= PCG_LEN_W'(PCG_MAX_LENGTH);
      rate_r <= PCG_RATE_W'(1);
    end else if (we) begin
      case (cfg_index)
        PCG_REG_LENGTH: len_r  <= cfg_data[PCG_LEN_W-1:0];
        PCG_REG_RATE:   rate_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective length, modulus and multiplier
  always_comb begin
    if (len_r == '0) lenc = LW'(1);
    else if (32'(len_r) > MAX_LENGTH) lenc = LW'(MAX_LENGTH);
    else lenc = LW'(len_r);
  end
  assign modv = {lenc, 1'b0};
  assign aval = (lenc == LW'(1)) ? '0 : MW'(lenc) + MW'(1);
  assign absn = rate_r[PCG_RATE_W-1] ? PCG_RATE_W'(-rate_r) : rate_r;
  assign nres = (rate_r[PCG_RATE_W-1] && rem_r != '0) ? modv - rem_r : rem_r;
  assign prod = PW'(aval) * PW'(nres);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CFG_IDLE: state_nxt = CFG_IDLE;
      CFG_LOAD: state_nxt = CFG_RATE;
      CFG_RATE: if (cnt_r == '0) state_nxt = CFG_PROD;
      CFG_PROD: if (cnt_r == '0) state_nxt = CFG_IDLE;
      default:  state_nxt = CFG_IDLE;
    endcase
    if (we) state_nxt = CFG_LOAD;
  end

  // reducer datapath
  always_comb begin
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    word_nxt = word_r;
    kval_nxt = kval_r;
    case (state_r)
      CFG_LOAD: begin
        word_nxt = WW'(absn) << (WW - PCG_RATE_W);
        rem_nxt  = '0;
        cnt_nxt  = CW'(PCG_RATE_W);
      end
      CFG_RATE: begin
        if (cnt_r != '0) begin
          rem_nxt  = mod_step(rem_r, word_r[WW-1], modv);
          word_nxt = word_r << 1;
          cnt_nxt  = cnt_r - CW'(1);
        end else begin
          word_nxt = WW'(prod) << (WW - PW);
          rem_nxt  = '0;
          cnt_nxt  = CW'(PW);
        end
      end
      CFG_PROD: begin
        if (cnt_r != '0) begin
          rem_nxt  = mod_step(rem_r, word_r[WW-1], modv);
          word_nxt = word_r << 1;
          cnt_nxt  = cnt_r - CW'(1);
        end else begin
          kval_nxt = rem_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CFG_LOAD;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    word_r <= word_nxt;
    kval_r <= kval_nxt;
  end

  assign busy   = (state_r != CFG_IDLE) || we;
  assign len_o  = lenc;
  assign mod_o  = modv;
  assign kval_o = kval_r;

endmodule

// File: rtl/pcg_front.sv
// ----------------------------------------------------------------------------
// Periodic chirp generator front end
// Takes index beats and queues them for the compute pipeline.
// ----------------------------------------------------------------------------
module pcg_front
  import pcg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,   // [11:0] sample_index
  input  logic                 busy,
  output logic                 item_valid,
  output logic [PCG_IDX_W-1:0] item_index,
  input  logic                 take
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [PCG_IDX_W-1:0] q_mem [DEPTH];
  logic [AW-1:0]        wr_ptr_r, rd_ptr_r;
  logic [AW:0]          cnt_r;
  logic                 push, pop;

  assign in_tready  = (cnt_r != (AW+1)'(DEPTH)) && !busy;
  assign push       = in_tvalid && in_tready;
  assign item_valid = (cnt_r != '0);
  assign pop        = take && item_valid;
  assign item_index = q_mem[rd_ptr_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr_r] <= in_tdata[PCG_IDX_W-1:0];
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + AW'(1);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (AW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (AW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: rtl/pcg_poly_step.sv
// ----------------------------------------------------------------------------
// Periodic chirp generator series step
// One Horner step of the sine and cosine lanes, three register stages.
// ----------------------------------------------------------------------------
module pcg_poly_step
  import pcg_pkg::*;
#(
  parameter int unsigned SIN_D = 6,
  parameter int unsigned COS_D = 12,
  parameter bit          LAST  = 1'b0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  pcg_poly_t in_d,
  output logic      out_valid,
  output pcg_poly_t out_d
);

  // reciprocals, floor(2^32 / d)
  localparam logic [31:0] SIN_M = 32'((64'd1 << 32) / SIN_D);
  localparam logic [31:0] COS_M = 32'((64'd1 << 32) / COS_D);

  logic      a_v_r, b_v_r, c_v_r;
  pcg_poly_t a_d_r, b_d_r, c_d_r;
  logic [31:0] a_ys_r, a_yc_r, b_ys_r, b_yc_r;
  logic [63:0] b_ts_r, b_tc_r;
  logic [63:0] ps, pc;
  logic [31:0] qs, qc;
  logic [39:0] rs, rc;
  logic [31:0] hs_full;
  logic signed [32:0] dc;
  pcg_poly_t c_nxt;

  assign ps = 64'(LAST ? {1'b0, in_d.x} : in_d.x2) * 64'(in_d.hs);
  assign pc = 64'(in_d.x2) * 64'(in_d.hc);

  // stage A: products with h
  always_ff @(posedge clk) begin
    if (en) begin
      a_d_r  <= in_d;
      a_ys_r <= ps[61:30];
      a_yc_r <= pc[61:30];
    end
  end

  // stage B: reciprocal products
  always_ff @(posedge clk) begin
    if (en) begin
      b_d_r  <= a_d_r;
      b_ys_r <= a_ys_r;
      b_yc_r <= a_yc_r;
      b_ts_r <= 64'(a_ys_r) * 64'(SIN_M);
      b_tc_r <= 64'(a_yc_r) * 64'(COS_M);
    end
  end

  // stage C: quotient correction and new h
  always_comb begin
    qs = b_ts_r[63:32];
    qc = b_tc_r[63:32];
    rs = 40'(b_ys_r) - 40'(qs) * 40'(SIN_D);
    rc = 40'(b_yc_r) - 40'(qc) * 40'(COS_D);
    if (rs >= 40'(SIN_D)) qs = qs + 32'd1;
    if (rc >= 40'(COS_D)) qc = qc + 32'd1;
    hs_full = 32'(PCG_ONE_Q30) - qs;
    dc = $signed({2'b00, PCG_ONE_Q30}) - $signed({1'b0, qc});
    c_nxt = b_d_r;
    c_nxt.hs = LAST ? b_ys_r[30:0] : hs_full[30:0];
    c_nxt.hc = (dc < 0) ? '0 : dc[30:0];
  end

  always_ff @(posedge clk) begin
    if (en) c_d_r <= c_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  assign out_valid = c_v_r;
  assign out_d     = c_d_r;

endmodule

// File: rtl/pcg_back.sv
// ----------------------------------------------------------------------------
// Periodic chirp generator back end
// Residue, angle division and series evaluation as one stalling pipeline.
// ----------------------------------------------------------------------------
module pcg_back
  import pcg_pkg::*;
#(
  parameter  int unsigned MAX_LENGTH = PCG_MAX_LENGTH,
  localparam int unsigned LW = $clog2(MAX_LENGTH + 1),
  localparam int unsigned MW = LW + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  logic [PCG_IDX_W-1:0] item_index,
  output logic                 take,
  input  logic [LW-1:0]        len_i,
  input  logic [MW-1:0]        mod_i,
  input  logic [MW-1:0]        kval_i,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PCG_OUT_W-1:0] cos_o,
  output logic [PCG_OUT_W-1:0] sin_o
);

  localparam int unsigned PW = 2 * MW;
  localparam int unsigned NW = LW + PCG_X_W;
  localparam int unsigned SQ = PCG_SQ_W;
  localparam int unsigned XW = PCG_X_W;

  function automatic logic [MW-1:0] mod_step(input logic [MW-1:0] rem, input logic b,
                                             input logic [MW-1:0] md);
    logic [MW:0] t;
    t = {rem, b};
    if (t >= {1'b0, md}) t = t - {1'b0, md};
    return t[MW-1:0];
  endfunction

  function automatic logic [PCG_OUT_W-1:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) return 16'h7FFF;
    return v[15:0];
  endfunction

  logic en;
  logic out_v_r;
  logic [PCG_OUT_W-1:0] cos_r, sin_r;

  assign en   = !out_v_r || out_ready;
  assign take = en;

  // square of the index
  logic          s0_v_r;
  logic [SQ-1:0] s0_sq_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s0_v_r <= 1'b0;
    else if (en) s0_v_r <= item_valid;
  end
  always_ff @(posedge clk) begin
    if (en) s0_sq_r <= {{PCG_IDX_W{1'b0}}, item_index} * {{PCG_IDX_W{1'b0}}, item_index};
  end

  // m*m mod 2L, one bit per stage
  logic          r1_v_r    [SQ];
  logic [MW-1:0] r1_rem_r  [SQ];
  logic [SQ-1:0] r1_word_r [SQ];
  for (genvar j = 0; j < SQ; j++) begin : g_r1
    logic          vin;
    logic [MW-1:0] rin;
    logic [SQ-1:0] win;
    if (j == 0) begin : g_first
      assign vin = s0_v_r;
      assign rin = '0;
      assign win = s0_sq_r;
    end else begin : g_next
      assign vin = r1_v_r[j-1];
      assign rin = r1_rem_r[j-1];
      assign win = r1_word_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) r1_v_r[j] <= 1'b0;
      else if (en) r1_v_r[j] <= vin;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        r1_rem_r[j]  <= mod_step(rin, win[SQ-1], mod_i);
        r1_word_r[j] <= win << 1;
      end
    end
  end

  // K * (m*m mod 2L)
  logic          s2_v_r;
  logic [PW-1:0] s2_p_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (en) s2_v_r <= r1_v_r[SQ-1];
  end
  always_ff @(posedge clk) begin
    if (en) s2_p_r <= PW'(kval_i) * PW'(r1_rem_r[SQ-1]);
  end

  // product mod 2L
  logic          r2_v_r    [PW];
  logic [MW-1:0] r2_rem_r  [PW];
  logic [PW-1:0] r2_word_r [PW];
  for (genvar j = 0; j < PW; j++) begin : g_r2
    logic          vin;
    logic [MW-1:0] rin;
    logic [PW-1:0] win;
    if (j == 0) begin : g_first
      assign vin = s2_v_r;
      assign rin = '0;
      assign win = s2_p_r;
    end else begin : g_next
      assign vin = r2_v_r[j-1];
      assign rin = r2_rem_r[j-1];
      assign win = r2_word_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) r2_v_r[j] <= 1'b0;
      else if (en) r2_v_r[j] <= vin;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        r2_rem_r[j]  <= mod_step(rin, win[PW-1], mod_i);
        r2_word_r[j] <= win << 1;
      end
    end
  end

  // quadrant and remainder of 2r / L
  logic          s3_v_r;
  logic [LW-1:0] s3_e_r;
  logic [1:0]    s3_q_r;
  logic [MW:0]   tw0, tw1, tw2;
  logic [1:0]    qsel;
  always_comb begin
    tw0     = {r2_rem_r[PW-1], 1'b0};
    qsel[1] = (tw0 >= {1'b0, mod_i});
    tw1     = qsel[1] ? tw0 - {1'b0, mod_i} : tw0;
    qsel[0] = (tw1 >= (MW+1)'(len_i));
    tw2     = qsel[0] ? tw1 - (MW+1)'(len_i) : tw1;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (en) s3_v_r <= r2_v_r[PW-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_e_r <= tw2[LW-1:0];
      s3_q_r <= qsel;
    end
  end

  // numerator e*pi/2 + L/2
  logic          s4_v_r;
  logic [NW-1:0] s4_n_r;
  logic [1:0]    s4_q_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (en) s4_v_r <= s3_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_n_r <= NW'(s3_e_r) * NW'(PCG_HALFPI_Q30) + NW'(len_i >> 1);
      s4_q_r <= s3_q_r;
    end
  end

  // restoring divide by L, one quotient bit per stage
  logic          dv_v_r    [XW];
  logic [LW-1:0] dv_rem_r  [XW];
  logic [XW-1:0] dv_word_r [XW];
  logic [1:0]    dv_q_r    [XW];
  for (genvar j = 0; j < XW; j++) begin : g_div
    logic          vin;
    logic [LW-1:0] rin;
    logic [XW-1:0] win;
    logic [1:0]    qin;
    logic [LW:0]   t;
    logic          qb;
    if (j == 0) begin : g_first
      assign vin = s4_v_r;
      assign rin = s4_n_r[NW-1:XW];
      assign win = s4_n_r[XW-1:0];
      assign qin = s4_q_r;
    end else begin : g_next
      assign vin = dv_v_r[j-1];
      assign rin = dv_rem_r[j-1];
      assign win = dv_word_r[j-1];
      assign qin = dv_q_r[j-1];
    end
    assign t  = {rin, win[XW-1]};
    assign qb = (t >= {1'b0, len_i});
    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[j] <= 1'b0;
      else if (en) dv_v_r[j] <= vin;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[j]  <= qb ? LW'(t - {1'b0, len_i}) : LW'(t);
        dv_word_r[j] <= {win[XW-2:0], qb};
        dv_q_r[j]    <= qin;
      end
    end
  end

  // x squared
  logic        s5_v_r;
  pcg_poly_t   s5_d_r;
  logic [61:0] xx;
  assign xx = 62'(dv_word_r[XW-1]) * 62'(dv_word_r[XW-1]);
  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else if (en) s5_v_r <= dv_v_r[XW-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s5_d_r.x    <= dv_word_r[XW-1];
      s5_d_r.x2   <= xx[61:30];
      s5_d_r.hs   <= PCG_ONE_Q30;
      s5_d_r.hc   <= PCG_ONE_Q30;
      s5_d_r.quad <= dv_q_r[XW-1];
    end
  end

  // Horner chain, both lanes side by side
  logic      pv [PCG_POLY_STEPS+2];
  pcg_poly_t pd [PCG_POLY_STEPS+2];
  assign pv[0] = s5_v_r;
  assign pd[0] = s5_d_r;
  for (genvar k = 0; k < PCG_POLY_STEPS; k++) begin : g_poly
    pcg_poly_step #(
      .SIN_D (PCG_SIN_DIV[k]),
      .COS_D (PCG_COS_DIV[k]),
      .LAST  (1'b0)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (pv[k]),
      .in_d      (pd[k]),
      .out_valid (pv[k+1]),
      .out_d     (pd[k+1])
    );
  end
  pcg_poly_step #(
    .SIN_D (1),
    .COS_D (PCG_COS_LAST_DIV),
    .LAST  (1'b1)
  ) u_step_last (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pv[PCG_POLY_STEPS]),
    .in_d      (pd[PCG_POLY_STEPS]),
    .out_valid (pv[PCG_POLY_STEPS+1]),
    .out_d     (pd[PCG_POLY_STEPS+1])
  );

  // Q15 rounding, quadrant mapping, output register
  pcg_poly_t          fin;
  logic [31:0]        sr, cr;
  logic signed [17:0] sv, cv, co, so;
  always_comb begin
    fin = pd[PCG_POLY_STEPS+1];
    sr  = 32'(fin.hs) + PCG_HALF_Q15;
    cr  = 32'(fin.hc) + PCG_HALF_Q15;
    sv  = $signed({1'b0, sr[31:15]});
    cv  = $signed({1'b0, cr[31:15]});
    case (fin.quad)
      2'd0:    begin co = cv;  so = sv;  end
      2'd1:    begin co = -sv; so = cv;  end
      2'd2:    begin co = -cv; so = -sv; end
      default: begin co = sv;  so = -cv; end
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (en) out_v_r <= pv[PCG_POLY_STEPS+1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= sat16(co);
      sin_r <= sat16(so);
    end
  end

  assign out_valid = out_v_r;
  assign cos_o     = cos_r;
  assign sin_o     = sin_r;

endmodule

// File: rtl/pcg_checker.sv
// ----------------------------------------------------------------------------
// Periodic chirp generator port checker
// Watches the top-level ports for reset, stall and setup behavior.
// ----------------------------------------------------------------------------
`include "periodic_chirp_generator_macros.svh"

module pcg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // a stalled output beat holds
  `PCG_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "output beat changed while stalled")

  // input closes while K is rebuilt after a write
  `PCG_ASSERT(a_cfg_busy, cfg_valid && cfg_ready |=> !in_tready, "input open right after a register write")

  // reset empties the pipeline and starts setup
  `PCG_ASSERT_RST(a_reset, !rst_n |=> !out_tvalid && !in_tready, "block not quiet after reset")

endmodule

bind periodic_chirp_generator pcg_checker u_pcg_checker (.*);
